@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the ray caster checker. Each macro expands to one
// labeled concurrent assertion on a clock and an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define GDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/gdr_pkg.sv @@
// ---------------------------------------------------------------------------
// gdr_pkg
// Types, constants and helpers shared by the grid ray caster modules.
// ---------------------------------------------------------------------------
package gdr_pkg;

    // fixed-point and geometry constants
    localparam int FRAC_BITS     = 16;
    localparam int MAP_WIDTH     = 64;
    localparam int MAP_HEIGHT    = 64;
    localparam int MAP_DEPTH     = MAP_WIDTH * MAP_HEIGHT;
    localparam int MAP_AW        = $clog2(MAP_DEPTH);
    localparam int CELL_W        = $clog2(MAP_WIDTH);
    localparam int SCREEN_HEIGHT = 768;

    // datapath widths
    localparam int SIDE_W   = 48;   // side and delta distances
    localparam int MUL_AW   = 18;   // narrow multiplier operand
    localparam int PROD_W   = MUL_AW + SIDE_W;
    localparam int DIVQ_W   = 33;   // divider dividend and quotient
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 22;

    localparam logic [SIDE_W-1:0] SAT_CAP      = {SIDE_W{1'b1}};
    localparam logic [DIVQ_W-1:0] RECIP_NUM    = 33'h1_0000_0000;
    localparam logic [DIVQ_W-1:0] LH_NUM       = 33'd50331648;
    localparam logic [10:0]       LH_CAP       = 11'd1536;
    localparam logic [9:0]        HALF_HEIGHT  = 10'd384;
    localparam logic [9:0]        ROW_LAST     = 10'd767;
    localparam logic [22:0]       HIT_MAX      = 23'd4194304;
    localparam logic [23:0]       DIST_OUT_MAX = 24'hFF_FFFF;
    localparam logic [7:0]        WALK_LIMIT   = 8'd132;
    localparam logic [31:0]       SHADE_X      = 32'hCCCC_CCFF;
    localparam logic [31:0]       SHADE_Y      = 32'h8888_88FF;
    localparam logic signed [17:0] CAM_ONE     = 18'sd65536;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_PLAYER_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PLANE_Y  = 3'd5;

    // request commands
    localparam logic CMD_CAST  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_is_wall;
    } gdr_in_t;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [9:0]  row_top;
        logic [9:0]  row_bottom;
        logic        hit_side;
        logic [31:0] shade;
        logic [23:0] wall_distance;
        logic [22:0] hit_point_x;
        logic [22:0] hit_point_y;
    } gdr_out_t;

    // map write port
    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        logic              data;
    } gdr_map_wr_t;

    // magnitude of a ray component
    function automatic logic [MUL_AW-1:0] mag20(input logic signed [19:0] v);
        logic [19:0] n;
        n = -v;
        return v[19] ? n[MUL_AW-1:0] : v[MUL_AW-1:0];
    endfunction

    // product shifted down by the fraction bits, saturated at the cap
    function automatic logic [SIDE_W-1:0] sat_mul(input logic [PROD_W-1:0] p);
        return (p[PROD_W-1:SIDE_W+FRAC_BITS] != '0) ? SAT_CAP
                                                     : p[SIDE_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

endpackage

@@ hw/rtl/gdr_map.sv @@
// ---------------------------------------------------------------------------
// gdr_map
// One-bit wall map memory with registered read and a clearing sweep after
// reset that writes every cell open.
// ---------------------------------------------------------------------------
module gdr_map import gdr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  gdr_map_wr_t       wr,
    input  logic [MAP_AW-1:0] rd_addr,
    output logic              rd_data,
    output logic              clearing
);

    localparam logic [MAP_AW-1:0] ADDR_LAST = MAP_AW'(MAP_DEPTH - 1);

    logic              mem [MAP_DEPTH];
    logic              clear_reg;
    logic [MAP_AW-1:0] clr_addr_reg;
    logic              rd_data_reg;

    // clearing sweep control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clear_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_LAST) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // single write port, sweep has priority
    always_ff @(posedge aclk) begin
        if (clear_reg) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

@@ hw/rtl/gdr_div.sv @@
// ---------------------------------------------------------------------------
// gdr_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// reciprocal and line height divisions.
// ---------------------------------------------------------------------------
module gdr_div import gdr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVQ_W-1:0] dividend,
    input  logic [SIDE_W-1:0] divisor,
    output logic              done,
    output logic [DIVQ_W-1:0] quotient
);

    localparam logic [5:0] DIV_STEPS = 6'(DIVQ_W);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [SIDE_W-1:0] rem_reg;
    logic [SIDE_W-1:0] den_reg;
    logic [DIVQ_W-1:0] quo_reg;

    logic [SIDE_W:0]   trial;
    logic [SIDE_W:0]   diff;
    logic              ge;

    // one trial subtraction
    assign trial = {rem_reg, quo_reg[DIVQ_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
            quo_reg <= {quo_reg[DIVQ_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/gdr_mul.sv @@
// ---------------------------------------------------------------------------
// gdr_mul
// Unsigned 18 by 48 bit multiplier built from two 18 by 24 bit partial
// products: the low one is registered, then the high one is added in.
// ---------------------------------------------------------------------------
module gdr_mul import gdr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_AW-1:0] a,
    input  logic [SIDE_W-1:0] b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    localparam int HALF_W = SIDE_W / 2;
    localparam int PART_W = MUL_AW + HALF_W;

    logic              phase_reg;
    logic              done_reg;
    logic [PART_W-1:0] lo_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PART_W-1:0] part_lo;
    logic [PART_W-1:0] part_hi;

    assign part_lo = a * b[HALF_W-1:0];
    assign part_hi = a * b[SIDE_W-1:HALF_W];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= start;
            done_reg  <= phase_reg;
        end
    end

    // low half first, then high half added in
    always_ff @(posedge aclk) begin
        if (start) begin
            lo_reg <= part_lo;
        end
        if (phase_reg) begin
            prod_reg <= PROD_W'(lo_reg) + {part_hi, {HALF_W{1'b0}}};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ hw/rtl/grid_dda_raycaster_unit.sv @@
// ---------------------------------------------------------------------------
// grid_dda_raycaster_unit
// Wall map plus fixed-point DDA ray caster: write requests load map cells,
// cast requests walk the grid for one screen column and return the slice.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   s_       in         s_valid / s_ready    gdr_in_t  (cast or cell write)
//   m_       out        m_valid / m_ready    gdr_out_t (one per cast)
//
// A cell write goes straight to the map when accepted. A cast holds the
// block while it makes up to three passes through the shared divider (the
// line height division is skipped when the distance is zero) and walks the
// grid with one map read per cell. After reset the map is swept open with
// s_ready low. A finished cast waits in its last state while the output
// register is full and m_ready is low.
// ---------------------------------------------------------------------------
module grid_dda_raycaster_unit import gdr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_write,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  gdr_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gdr_out_t          m_data
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_CAMX    = 5'd1;
    localparam logic [4:0] ST_CAMY    = 5'd2;
    localparam logic [4:0] ST_RY      = 5'd3;
    localparam logic [4:0] ST_DX_GO   = 5'd4;
    localparam logic [4:0] ST_DX_WAIT = 5'd5;
    localparam logic [4:0] ST_DY_GO   = 5'd6;
    localparam logic [4:0] ST_DY_WAIT = 5'd7;
    localparam logic [4:0] ST_SX_GO   = 5'd8;
    localparam logic [4:0] ST_SX_WAIT = 5'd9;
    localparam logic [4:0] ST_SY_GO   = 5'd10;
    localparam logic [4:0] ST_SY_WAIT = 5'd11;
    localparam logic [4:0] ST_STEP    = 5'd12;
    localparam logic [4:0] ST_CHECK   = 5'd13;
    localparam logic [4:0] ST_DIST    = 5'd14;
    localparam logic [4:0] ST_LH_GO   = 5'd15;
    localparam logic [4:0] ST_LH_WAIT = 5'd16;
    localparam logic [4:0] ST_HX_GO   = 5'd17;
    localparam logic [4:0] ST_HX_WAIT = 5'd18;
    localparam logic [4:0] ST_HY_GO   = 5'd19;
    localparam logic [4:0] ST_HY_WAIT = 5'd20;
    localparam logic [4:0] ST_DONE    = 5'd21;

    localparam logic [7:0] MAP_W8 = 8'(MAP_WIDTH);
    localparam logic [7:0] MAP_H8 = 8'(MAP_HEIGHT);

    // configuration registers
    logic [21:0]        player_x_reg, player_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    // sequencer and walk state
    logic [4:0]         state_reg, state_next;
    logic [9:0]         col_reg;
    logic signed [35:0] cam_prod_reg;
    logic signed [19:0] rx_reg, ry_reg;
    logic [SIDE_W-1:0]  dx_reg, dy_reg, sx_reg, sy_reg, dist_reg;
    logic [7:0]         mx_reg, my_reg, guard_reg;
    logic               side_reg;
    logic [10:0]        lh_reg;
    logic [22:0]        hx_reg, hy_reg;
    logic               m_valid_reg;
    gdr_out_t           m_data_reg;

    logic               accept, cast_accept;
    logic signed [17:0] cam_fx, cam_plane;
    logic signed [35:0] cam_prod;
    logic [MUL_AW-1:0]  rx_mag, ry_mag;
    logic               rx_neg, ry_neg;

    logic               mul_start, mul_done;
    logic [MUL_AW-1:0]  mul_a;
    logic [SIDE_W-1:0]  mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [DIVQ_W-1:0]  div_num, div_quo;
    logic [SIDE_W-1:0]  div_den;

    logic               step_x, outside;
    logic [SIDE_W:0]    sum_x, sum_y;
    logic [SIDE_W-1:0]  sx_add, sy_add;
    logic [7:0]         mx_new, my_new;
    logic [SIDE_W-1:0]  dist_val;

    logic               hit_y, hit_neg;
    logic [SIDE_W-1:0]  hit_m, hit_base;
    logic [SIDE_W:0]    hit_raw;
    logic [22:0]        hit_val;

    logic [9:0]         half_lh;
    logic [10:0]        end_raw;
    logic [9:0]         row_top, row_bottom;
    logic               out_load;

    gdr_map_wr_t        map_wr;
    logic [MAP_AW-1:0]  map_rd_addr;
    logic               map_rd_data, map_clearing;

    assign s_ready     = (state_reg == ST_IDLE) && !map_clearing;
    assign accept      = s_valid && s_ready;
    assign cast_accept = accept && (s_data.cmd == CMD_CAST);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_x_reg <= '0;
            player_y_reg <= '0;
            dir_x_reg    <= 18'sd65536;
            dir_y_reg    <= '0;
            plane_x_reg  <= '0;
            plane_y_reg  <= 18'sd43254;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_PLAYER_X: player_x_reg <= cfg_data;
                CFG_PLAYER_Y: player_y_reg <= cfg_data;
                CFG_DIR_X:    dir_x_reg    <= $signed(cfg_data[17:0]);
                CFG_DIR_Y:    dir_y_reg    <= $signed(cfg_data[17:0]);
                CFG_PLANE_X:  plane_x_reg  <= $signed(cfg_data[17:0]);
                CFG_PLANE_Y:  plane_y_reg  <= $signed(cfg_data[17:0]);
                default: ;
            endcase
        end
    end

    // map write straight from an accepted write request
    assign map_wr.en   = accept && (s_data.cmd == CMD_WRITE);
    assign map_wr.addr = {s_data.cell_y, s_data.cell_x};
    assign map_wr.data = s_data.cell_is_wall;

    // camera offset and plane product
    assign cam_fx    = $signed({1'b0, col_reg, 7'b0}) - CAM_ONE;
    assign cam_plane = (state_reg == ST_CAMX) ? plane_x_reg : plane_y_reg;
    assign cam_prod  = cam_plane * cam_fx;

    assign rx_neg = rx_reg[19];
    assign ry_neg = ry_reg[19];
    assign rx_mag = mag20(rx_reg);
    assign ry_mag = mag20(ry_reg);

    // multiplier operands
    always_comb begin
        mul_a = rx_mag;
        mul_b = dist_reg;
        unique case (state_reg)
            ST_SX_GO, ST_SX_WAIT: begin
                mul_a = rx_neg ? MUL_AW'(player_x_reg[15:0])
                               : MUL_AW'(17'h1_0000 - {1'b0, player_x_reg[15:0]});
                mul_b = dx_reg;
            end
            ST_SY_GO, ST_SY_WAIT: begin
                mul_a = ry_neg ? MUL_AW'(player_y_reg[15:0])
                               : MUL_AW'(17'h1_0000 - {1'b0, player_y_reg[15:0]});
                mul_b = dy_reg;
            end
            ST_HY_GO, ST_HY_WAIT: begin
                mul_a = ry_mag;
            end
            default: ;
        endcase
    end

    assign mul_start = (state_reg == ST_SX_GO) || (state_reg == ST_SY_GO) ||
                       (state_reg == ST_HX_GO) || (state_reg == ST_HY_GO);

    // divider operands
    always_comb begin
        div_num = RECIP_NUM;
        div_den = SIDE_W'(rx_mag);
        unique case (state_reg)
            ST_DY_GO: div_den = SIDE_W'(ry_mag);
            ST_LH_GO: begin
                div_num = LH_NUM;
                div_den = dist_reg;
            end
            default: ;
        endcase
    end

    assign div_start = (state_reg == ST_DX_GO) || (state_reg == ST_DY_GO) ||
                       ((state_reg == ST_LH_GO) && (dist_reg != '0));

    // one DDA step
    assign step_x  = sx_reg < sy_reg;
    assign sum_x   = {1'b0, sx_reg} + {1'b0, dx_reg};
    assign sum_y   = {1'b0, sy_reg} + {1'b0, dy_reg};
    assign sx_add  = sum_x[SIDE_W] ? SAT_CAP : sum_x[SIDE_W-1:0];
    assign sy_add  = sum_y[SIDE_W] ? SAT_CAP : sum_y[SIDE_W-1:0];
    assign mx_new  = !step_x ? mx_reg : (rx_neg ? mx_reg - 8'd1 : mx_reg + 8'd1);
    assign my_new  = step_x ? my_reg : (ry_neg ? my_reg - 8'd1 : my_reg + 8'd1);
    // a negative index wraps above the map size
    assign outside = (mx_new >= MAP_W8) || (my_new >= MAP_H8);
    assign map_rd_addr = {my_new[CELL_W-1:0], mx_new[CELL_W-1:0]};

    // perpendicular distance from the last stepped axis
    always_comb begin
        if (side_reg) begin
            dist_val = (sy_reg > dy_reg) ? sy_reg - dy_reg : '0;
        end else begin
            dist_val = (sx_reg > dx_reg) ? sx_reg - dx_reg : '0;
        end
    end

    // hit point along one axis
    assign hit_y    = (state_reg == ST_HY_WAIT);
    assign hit_neg  = hit_y ? ry_neg : rx_neg;
    assign hit_base = SIDE_W'(hit_y ? player_y_reg : player_x_reg);
    assign hit_m    = sat_mul(mul_prod);
    always_comb begin
        if (hit_neg) begin
            hit_raw = (hit_base > hit_m) ? {1'b0, hit_base - hit_m} : '0;
        end else begin
            hit_raw = {1'b0, hit_base} + {1'b0, hit_m};
        end
        hit_val = (hit_raw > (SIDE_W+1)'(HIT_MAX)) ? HIT_MAX : hit_raw[22:0];
    end

    // slice span
    assign half_lh    = lh_reg[10:1];
    assign row_top    = (half_lh >= HALF_HEIGHT) ? '0 : HALF_HEIGHT - half_lh;
    assign end_raw    = {1'b0, half_lh} + {1'b0, HALF_HEIGHT};
    assign row_bottom = (end_raw > {1'b0, ROW_LAST}) ? ROW_LAST : end_raw[9:0];

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (cast_accept) state_next = ST_CAMX;
            ST_CAMX:    state_next = ST_CAMY;
            ST_CAMY:    state_next = ST_RY;
            ST_RY:      state_next = ST_DX_GO;
            ST_DX_GO:   state_next = ST_DX_WAIT;
            ST_DX_WAIT: if (div_done) state_next = ST_DY_GO;
            ST_DY_GO:   state_next = ST_DY_WAIT;
            ST_DY_WAIT: if (div_done) state_next = ST_SX_GO;
            ST_SX_GO:   state_next = ST_SX_WAIT;
            ST_SX_WAIT: if (mul_done) state_next = ST_SY_GO;
            ST_SY_GO:   state_next = ST_SY_WAIT;
            ST_SY_WAIT: if (mul_done) state_next = ST_STEP;
            ST_STEP:    state_next = outside ? ST_DIST : ST_CHECK;
            ST_CHECK: begin
                if (map_rd_data || (guard_reg == WALK_LIMIT)) begin
                    state_next = ST_DIST;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_DIST:    state_next = ST_LH_GO;
            ST_LH_GO:   state_next = (dist_reg == '0) ? ST_HX_GO : ST_LH_WAIT;
            ST_LH_WAIT: if (div_done) state_next = ST_HX_GO;
            ST_HX_GO:   state_next = ST_HX_WAIT;
            ST_HX_WAIT: if (mul_done) state_next = ST_HY_GO;
            ST_HY_GO:   state_next = ST_HY_WAIT;
            ST_HY_WAIT: if (mul_done) state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE:    if (cast_accept) col_reg <= s_data.column;
            ST_CAMX:    cam_prod_reg <= cam_prod;
            ST_CAMY: begin
                rx_reg       <= 20'(dir_x_reg) + cam_prod_reg[35:16];
                cam_prod_reg <= cam_prod;
            end
            ST_RY:      ry_reg <= 20'(dir_y_reg) + cam_prod_reg[35:16];
            ST_DX_WAIT: if (div_done) dx_reg <= (rx_reg == '0) ? SAT_CAP : SIDE_W'(div_quo);
            ST_DY_WAIT: if (div_done) dy_reg <= (ry_reg == '0) ? SAT_CAP : SIDE_W'(div_quo);
            ST_SX_WAIT: begin
                if (mul_done) begin
                    sx_reg    <= sat_mul(mul_prod);
                    mx_reg    <= 8'(player_x_reg[21:16]);
                    guard_reg <= '0;
                    side_reg  <= 1'b1;
                end
            end
            ST_SY_WAIT: begin
                if (mul_done) begin
                    sy_reg <= sat_mul(mul_prod);
                    my_reg <= 8'(player_y_reg[21:16]);
                end
            end
            ST_STEP: begin
                if (step_x) begin
                    sx_reg <= sx_add;
                end else begin
                    sy_reg <= sy_add;
                end
                side_reg  <= !step_x;
                mx_reg    <= mx_new;
                my_reg    <= my_new;
                guard_reg <= guard_reg + 8'd1;
            end
            ST_DIST:    dist_reg <= dist_val;
            ST_LH_GO:   if (dist_reg == '0) lh_reg <= LH_CAP;
            ST_LH_WAIT: begin
                if (div_done) begin
                    lh_reg <= (div_quo > DIVQ_W'(LH_CAP)) ? LH_CAP : div_quo[10:0];
                end
            end
            ST_HX_WAIT: if (mul_done) hx_reg <= hit_val;
            ST_HY_WAIT: if (mul_done) hy_reg <= hit_val;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_column    <= col_reg;
            m_data_reg.row_top       <= row_top;
            m_data_reg.row_bottom    <= row_bottom;
            m_data_reg.hit_side      <= side_reg;
            m_data_reg.shade         <= side_reg ? SHADE_Y : SHADE_X;
            m_data_reg.wall_distance <= (dist_reg > SIDE_W'(DIST_OUT_MAX)) ? DIST_OUT_MAX
                                                                          : dist_reg[23:0];
            m_data_reg.hit_point_x   <= hx_reg;
            m_data_reg.hit_point_y   <= hy_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    gdr_map u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (map_wr),
        .rd_addr  (map_rd_addr),
        .rd_data  (map_rd_data),
        .clearing (map_clearing)
    );

    gdr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    gdr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

endmodule

@@ hw/rtl/gdr_checker.sv @@
// ---------------------------------------------------------------------------
// gdr_checker
// Port-level checks on the ray caster, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gdr_checker import gdr_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              cfg_write,
    input logic [CFG_IW-1:0] cfg_index,
    input logic [CFG_DW-1:0] cfg_data,
    input logic              s_valid,
    input logic              s_ready,
    input gdr_in_t           s_data,
    input logic              m_valid,
    input logic              m_ready,
    input gdr_out_t          m_data
);

    // map sweep keeps requests out right after reset
    `GDR_ASSERT_NEXT(a_clear_after_reset, aclk, 1'b1, !aresetn, !s_ready)

    // a cast request occupies the block
    `GDR_ASSERT_NEXT(a_cast_busy, aclk, aresetn, s_valid && s_ready && (s_data.cmd == CMD_CAST), !s_ready)

    // a write request makes no result
    `GDR_ASSERT_NEXT(a_write_silent, aclk, aresetn, s_valid && s_ready && (s_data.cmd == CMD_WRITE) && !m_valid, !m_valid)

    // shade follows the face side and the span is ordered
    `GDR_ASSERT_IMPLY(a_result_shape, aclk, aresetn, m_valid, (m_data.shade == (m_data.hit_side ? SHADE_Y : SHADE_X)) && (m_data.row_top <= m_data.row_bottom))

    // stalled result holds
    `GDR_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind grid_dda_raycaster_unit gdr_checker u_gdr_checker (.*);

@@ dv/tb_grid_dda_raycaster_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_dda_raycaster_unit
// Self-checking bench for the grid ray caster. Map writes and column casts are
// sent through a valid/ready driver. A predictor in the bench keeps its own
// wall map and view registers and works out each slice. A monitor checks every
// returned slice, field by field, against the oldest prediction. The view
// registers are changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_grid_dda_raycaster_unit;
    import gdr_pkg::*;

    localparam longint unsigned DIST_CAP = 64'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE = 600;

    logic              aclk;
    logic              aresetn;
    logic              cfg_write;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    gdr_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    gdr_out_t          m_data;

    // predictor state
    bit                 wall_cells [MAP_DEPTH];
    logic [21:0]        pos_x, pos_y;
    logic signed [17:0] dir_x, dir_y, plane_x, plane_y;

    gdr_in_t  requests_pending [$];
    gdr_out_t slices_due [$];
    bit       no_idle;
    int       errors;
    int       quiet_cycles;

    grid_dda_raycaster_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // fixed-point helpers
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned scale_fx(longint unsigned a, longint unsigned b);
        longint unsigned p;
        if (b != 0 && a > 64'hFFFF_FFFF_FFFF_FFFF / b) return DIST_CAP;
        p = (a * b) >> FRAC_BITS;
        return (p > DIST_CAP) ? DIST_CAP : p;
    endfunction

    function automatic longint unsigned add_capped(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > DIST_CAP) ? DIST_CAP : s;
    endfunction

    function automatic longint unsigned inv_step(longint v);
        longint unsigned m;
        m = magnitude(v);
        if (m == 0) return DIST_CAP;
        return (64'd1 << (2 * FRAC_BITS)) / m;
    endfunction

    function automatic bit blocked(longint cx, longint cy);
        if (cx < 0 || cy < 0 || cx >= MAP_WIDTH || cy >= MAP_HEIGHT) return 1'b1;
        return wall_cells[cy * MAP_WIDTH + cx];
    endfunction

    function automatic longint unsigned hit_coord(longint unsigned base, longint d,
                                                  longint unsigned perp);
        longint unsigned m, v;
        m = scale_fx(magnitude(d), perp);
        if (d < 0) v = (base > m) ? base - m : 0;
        else v = base + m;
        return (v > 64'd4194304) ? 64'd4194304 : v;
    endfunction

    // ray walk for one column under the current view
    function automatic gdr_out_t cast_ray(logic [9:0] col);
        longint          cam, rx, ry, mx, my, stx, sty, st, en;
        longint unsigned dx, dy, sx, sy, frac, perp, lh;
        bit              side;
        gdr_out_t        r;
        cam = longint'(((64'(col) * 2) << FRAC_BITS) / 1024) - 65536;
        rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> FRAC_BITS);
        ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> FRAC_BITS);
        mx = longint'(64'(pos_x) >> FRAC_BITS);
        my = longint'(64'(pos_y) >> FRAC_BITS);
        dx = inv_step(rx);
        dy = inv_step(ry);
        frac = 64'(pos_x) & 64'hFFFF;
        stx = (rx < 0) ? -1 : 1;
        sx = (rx < 0) ? scale_fx(frac, dx) : scale_fx(64'h10000 - frac, dx);
        frac = 64'(pos_y) & 64'hFFFF;
        sty = (ry < 0) ? -1 : 1;
        sy = (ry < 0) ? scale_fx(frac, dy) : scale_fx(64'h10000 - frac, dy);
        side = 1'b1;
        for (int g = 0; g < MAP_WIDTH + MAP_HEIGHT + 4; g++) begin
            if (sx < sy) begin
                sx = add_capped(sx, dx);
                mx += stx;
                side = 1'b0;
            end else begin
                sy = add_capped(sy, dy);
                my += sty;
                side = 1'b1;
            end
            if (blocked(mx, my)) break;
        end
        if (!side) perp = (sx > dx) ? sx - dx : 0;
        else perp = (sy > dy) ? sy - dy : 0;
        if (perp == 0) lh = 1536;
        else begin
            lh = (64'd768 << FRAC_BITS) / perp;
            if (lh > 1536) lh = 1536;
        end
        st = 384 - longint'(lh / 2);
        if (st < 0) st = 0;
        en = longint'(lh / 2) + 384;
        if (en >= 768) en = 767;
        r.out_column    = col;
        r.row_top       = st[9:0];
        r.row_bottom    = en[9:0];
        r.hit_side      = side;
        r.shade         = side ? SHADE_Y : SHADE_X;
        r.wall_distance = (perp > 64'hFF_FFFF) ? 24'hFF_FFFF : perp[23:0];
        r.hit_point_x   = 23'(hit_coord(64'(pos_x), rx, perp));
        r.hit_point_y   = 23'(hit_coord(64'(pos_y), ry, perp));
        return r;
    endfunction

    // register model follows every write port strobe
    always @(posedge aclk) begin
        if (aresetn && cfg_write) begin
            case (cfg_index)
                CFG_PLAYER_X: pos_x   = cfg_data;
                CFG_PLAYER_Y: pos_y   = cfg_data;
                CFG_DIR_X:    dir_x   = cfg_data[17:0];
                CFG_DIR_Y:    dir_y   = cfg_data[17:0];
                CFG_PLANE_X:  plane_x = cfg_data[17:0];
                CFG_PLANE_Y:  plane_y = cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // request driver
    always @(posedge aclk) begin
        gdr_in_t nxt;
        bit      load;
        if (aresetn) begin
            load = 1'b0;
            if (s_valid && s_ready) begin
                if (s_data.cmd == CMD_WRITE)
                    wall_cells[{s_data.cell_y, s_data.cell_x}] = s_data.cell_is_wall;
                else
                    slices_due.push_back(cast_ray(s_data.column));
            end
            if ((!s_valid || s_ready) && requests_pending.size() > 0
                    && (no_idle || $urandom_range(99) >= 30)) begin
                nxt = requests_pending.pop_front();
                load = 1'b1;
            end
            if (load) begin
                s_data  <= nxt;
                s_valid <= 1'b1;
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        gdr_out_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (slices_due.size() == 0) begin
                    $display("%0t: unexpected slice for column %0d", $realtime,
                             m_data.out_column);
                    errors++;
                end else begin
                    e = slices_due.pop_front();
                    check_field("out_column", 32'(e.out_column), 32'(m_data.out_column));
                    check_field("row_top", 32'(e.row_top), 32'(m_data.row_top));
                    check_field("row_bottom", 32'(e.row_bottom), 32'(m_data.row_bottom));
                    check_field("hit_side", 32'(e.hit_side), 32'(m_data.hit_side));
                    check_field("shade", e.shade, m_data.shade);
                    check_field("wall_distance", 32'(e.wall_distance),
                                32'(m_data.wall_distance));
                    check_field("hit_point_x", 32'(e.hit_point_x), 32'(m_data.hit_point_x));
                    check_field("hit_point_y", 32'(e.hit_point_y), 32'(m_data.hit_point_y));
                end
            end
            m_ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_write || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_view(logic [21:0] px, logic [21:0] py, logic [17:0] vx,
                            logic [17:0] vy, logic [17:0] cx, logic [17:0] cy);
        put_reg(CFG_PLAYER_X, px);
        put_reg(CFG_PLAYER_Y, py);
        put_reg(CFG_DIR_X, {4'b0, vx});
        put_reg(CFG_DIR_Y, {4'b0, vy});
        put_reg(CFG_PLANE_X, {4'b0, cx});
        put_reg(CFG_PLANE_Y, {4'b0, cy});
        @(posedge aclk);
        cfg_write <= 1'b0;
    endtask

    // wait for the block to go quiet: all requests taken, all slices back
    task automatic drain();
        while (requests_pending.size() > 0 || s_valid || slices_due.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic queue_cast(logic [9:0] col);
        gdr_in_t r;
        r = gdr_in_t'($urandom);
        r.cmd = CMD_CAST;
        r.column = col;
        requests_pending.push_back(r);
    endtask

    task automatic queue_cell(logic [5:0] x, logic [5:0] y, logic wall);
        gdr_in_t r;
        r = gdr_in_t'($urandom);
        r.cmd = CMD_WRITE;
        r.cell_x = x;
        r.cell_y = y;
        r.cell_is_wall = wall;
        requests_pending.push_back(r);
    endtask

    // random mix of map edits and casts
    task automatic queue_mix(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1))
                queue_cell(6'($urandom), 6'($urandom), $urandom_range(99) < 30);
            else queue_cast(10'($urandom));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        no_idle   = 1'b0;
        errors    = 0;
        quiet_cycles = 0;
        pos_x = 0; pos_y = 0;
        dir_x = 18'sd65536; dir_y = 0; plane_x = 0; plane_y = 18'sd43254;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset view: player on the grid corner, zero distances on the edge
        queue_cast(10'd0);
        queue_cast(10'd1023);
        queue_cast(10'd512);
        queue_cast(10'd511);
        queue_cell(6'd0, 6'd0, 1'b1);
        queue_cell(6'd63, 6'd63, 1'b1);
        queue_cell(6'd63, 6'd0, 1'b1);
        queue_cell(6'd0, 6'd63, 1'b1);
        queue_cell(6'd2, 6'd0, 1'b1);
        queue_cast(10'd600);
        queue_cast(10'd1);
        queue_cell(6'd0, 6'd0, 1'b0);
        queue_cell(6'd2, 6'd0, 1'b0);
        queue_cast(10'd700);
        drain();

        // ignored register indexes
        put_reg(3'd6, '1);
        put_reg(3'd7, '1);
        @(posedge aclk);
        cfg_write <= 1'b0;

        // extremes of the view registers
        set_view(22'd0, 22'd0, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000);
        queue_cast(10'd0); queue_cast(10'd1023); queue_cast(10'd300);
        drain();
        set_view(22'h3FFFFF, 22'h3FFFFF, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF);
        queue_cast(10'd0); queue_cast(10'd1023); queue_cast(10'd800);
        drain();
        // both ray components zero
        set_view(22'h200000, 22'h208000, 18'd0, 18'd0, 18'd0, 18'd0);
        queue_cast(10'd5); queue_cast(10'd999);
        drain();

        // random views, one phase without any idling
        for (int ph = 0; ph < 9; ph++) begin
            set_view(22'($urandom), 22'($urandom), 18'($urandom), 18'($urandom),
                     18'($urandom), 18'($urandom));
            no_idle = (ph == 4);
            queue_mix(140);
            drain();
        end
        no_idle = 1'b0;

        repeat (SETTLE) @(posedge aclk);
        if (slices_due.size() > 0) begin
            $display("%0t: %0d slices never returned", $realtime, slices_due.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
